>>> rtl/hsl_pkg.sv
// hsl_pkg: shared types and constants of the HSL pixel adjuster.
// No dependencies; used by every module in rtl/.
`default_nettype none

package hsl_pkg;

	localparam int HueW  = 11;
	localparam int GainW = 12;
	localparam int OffW  = 9;
	localparam int CfgW  = 12;
	localparam int CfgIdxW = 2;

	localparam logic [HueW-1:0] HueFull = 11'h600;

	typedef enum logic [CfgIdxW-1:0] {
		CFG_HUE_SHIFT  = 2'd0,
		CFG_SAT_GAIN   = 2'd1,
		CFG_LUM_GAIN   = 2'd2,
		CFG_LUM_OFFSET = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic [7:0] red_in;
		logic [7:0] green_in;
		logic [7:0] blue_in;
		logic [7:0] alpha_in;
		logic       last_in;
	} pix_in_t;

	typedef struct packed {
		logic [7:0] red_out;
		logic [7:0] green_out;
		logic [7:0] blue_out;
		logic [7:0] alpha_out;
		logic       write_pixel;
		logic       last_out;
	} pix_out_t;

endpackage

`default_nettype wire

>>> rtl/hsl_adjust_pixel.sv
// hsl_adjust_pixel: top level of the HSL pixel adjuster.
// Uses hsl_pkg, hsl_div (two instances) and hsl_back.
//
// Usage:
//   in_valid/in_ready/in_data carry one RGBA pixel item; out_valid/out_ready/
//   out_data carry the adjusted pixel. An item moves on a clock edge with
//   valid and ready both high. Alpha zero gives write_pixel 0 and zero color.
//   cfg_we/cfg_idx/cfg_data write hue_shift, sat_gain, lum_gain, lum_offset;
//   write only while no item is in flight.
// Pipeline: nine stages (prep, three divider stages, gain multiply, clamp and
//   hue wrap, chroma multiply, ramp multiply, channel sum).
// Throughput: one item per cycle while the output is not stalled. All stages
//   share one enable that is high when the output register is empty or being
//   taken. While the receiver stalls a full output, the whole pipe holds and
//   in_ready is low, so no item is lost or repeated.
// Reset: arst_n clears all valid bits and loads the registers with hue shift
//   0, gains 256 (unity) and lightness offset 0.
`default_nettype none

module hsl_adjust_pixel
	import hsl_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire pix_in_t            in_data,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output pix_out_t                out_data,
	input  wire logic               cfg_we,
	input  wire logic [CfgIdxW-1:0] cfg_idx,
	input  wire logic [CfgW-1:0]    cfg_data
);

	typedef struct packed {
		logic            neg;
		logic [HueW-1:0] base;
		logic            czero;
		logic [7:0]      lum;
		logic [7:0]      alpha;
		logic            last;
		logic            wr;
	} mid_t;

	typedef struct packed {
		logic [7:0] alpha;
		logic       last;
		logic       wr;
	} side_t;

	logic [HueW-1:0]  hue_shift_q;
	logic [GainW-1:0] sat_gain_q, lum_gain_q;
	logic [OffW-1:0]  lum_offset_q;

	logic [8:0] vld_q;
	logic       en;

	// stage enable: advance unless the output holds an untaken item
	assign en = !vld_q[8] || out_ready;
	assign in_ready = en;
	assign out_valid = vld_q[8];

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hue_shift_q <= '0;
			sat_gain_q <= 12'd256;
			lum_gain_q <= 12'd256;
			lum_offset_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_idx))
				CFG_HUE_SHIFT:  hue_shift_q <= cfg_data[HueW-1:0];
				CFG_SAT_GAIN:   sat_gain_q <= cfg_data[GainW-1:0];
				CFG_LUM_GAIN:   lum_gain_q <= cfg_data[GainW-1:0];
				CFG_LUM_OFFSET: lum_offset_q <= cfg_data[OffW-1:0];
				default: ;
			endcase
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[7:0], in_valid};
		end
	end

	// stage 1: max/min selection per sextant
	logic [7:0] r, g, b;
	logic [7:0] c_c;
	logic [8:0] l2_c;
	logic signed [8:0] num_c;
	logic [HueW-1:0] base_c;

	always_comb begin
		r = in_data.red_in;
		g = in_data.green_in;
		b = in_data.blue_in;
		if (r > g) begin
			if (r > b) begin
				c_c = (g < b) ? (r - g) : (r - b);
				l2_c = (g < b) ? (9'(r) + 9'(g)) : (9'(r) + 9'(b));
				num_c = $signed(9'(g)) - $signed(9'(b));
				base_c = (g < b) ? 11'h600 : 11'h000;
			end else begin
				c_c = b - g; l2_c = 9'(b) + 9'(g);
				num_c = $signed(9'(r)) - $signed(9'(g)); base_c = 11'h400;
			end
		end else if (r < b) begin
			if (g > b) begin
				c_c = g - r; l2_c = 9'(g) + 9'(r);
				num_c = $signed(9'(b)) - $signed(9'(r)); base_c = 11'h200;
			end else begin
				c_c = b - r; l2_c = 9'(b) + 9'(r);
				num_c = $signed(9'(r)) - $signed(9'(g)); base_c = 11'h400;
			end
		end else begin
			c_c = g - b; l2_c = 9'(g) + 9'(b);
			num_c = $signed(9'(b)) - $signed(9'(r)); base_c = 11'h200;
		end
	end

	logic [7:0] c_s1, fold_s1, numabs_s1;
	mid_t mid_s1, mid_s2, mid_s3, mid_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			c_s1 <= c_c;
			fold_s1 <= (l2_c > 9'hFF) ? 8'(9'h1FF - l2_c) : l2_c[7:0];
			numabs_s1 <= num_c[8] ? 8'(-num_c) : num_c[7:0];
			mid_s1.neg <= num_c[8];
			mid_s1.base <= base_c;
			mid_s1.czero <= (c_c == 8'd0);
			mid_s1.lum <= l2_c[8:1];
			mid_s1.alpha <= in_data.alpha_in;
			mid_s1.last <= in_data.last_in;
			mid_s1.wr <= (in_data.alpha_in != 8'd0);
		end
	end

	// stages 2..4: hue and saturation quotients
	logic [8:0] hq, sq;

	hsl_div u_div_hue (
		.clk      (clk),
		.en       (en),
		.dividend ({numabs_s1, 8'd0}),
		.divisor  (c_s1),
		.quotient (hq)
	);

	hsl_div u_div_sat (
		.clk      (clk),
		.en       (en),
		.dividend ({c_s1, 8'd0}),
		.divisor  (fold_s1),
		.quotient (sq)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			mid_s2 <= mid_s1;
			mid_s3 <= mid_s2;
			mid_s4 <= mid_s3;
		end
	end

	// stage 5: signed hue, shift sum, gain products
	logic [HueW-1:0] hue_c;
	logic [8:0]      sat_c;
	logic [11:0]     hue_sum_s5;
	logic [20:0]     sat_prod_s5;
	logic [19:0]     lum_prod_s5;
	side_t           side_s5, side_s6, side_s7, side_s8, side_s9;

	always_comb begin
		if (mid_s4.czero) begin
			hue_c = '0;
			sat_c = '0;
		end else begin
			hue_c = mid_s4.neg ? (mid_s4.base - 11'(hq)) : (mid_s4.base + 11'(hq));
			sat_c = sq;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hue_sum_s5 <= 12'(hue_c) + 12'(hue_shift_q);
			sat_prod_s5 <= 21'(sat_c) * 21'(sat_gain_q);
			lum_prod_s5 <= 20'(mid_s4.lum) * 20'(lum_gain_q);
			side_s5 <= '{alpha: mid_s4.alpha, last: mid_s4.last, wr: mid_s4.wr};
		end
	end

	// stage 6: hue wrap, clamps; skipped pixels forced to black
	logic [HueW-1:0]   hue_w;
	logic [7:0]        sat_cl, lum_cl;
	logic signed [13:0] lum_sum;
	logic [HueW-1:0]   hue_s6;
	logic [7:0]        sat_s6, lum_s6;

	always_comb begin
		if (hue_sum_s5 >= 12'hC00) begin
			hue_w = 11'(hue_sum_s5 - 12'hC00);
		end else if (hue_sum_s5 >= 12'(HueFull)) begin
			hue_w = 11'(hue_sum_s5 - 12'(HueFull));
		end else begin
			hue_w = hue_sum_s5[HueW-1:0];
		end
		sat_cl = (sat_prod_s5[20:8] > 13'd255) ? 8'hFF : sat_prod_s5[15:8];
		lum_sum = $signed({2'b00, lum_prod_s5[19:8]}) + 14'(signed'(lum_offset_q));
		if (lum_sum > 14'sd255) begin
			lum_cl = 8'hFF;
		end else if (lum_sum < 14'sd0) begin
			lum_cl = 8'h00;
		end else begin
			lum_cl = lum_sum[7:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hue_s6 <= hue_w;
			sat_s6 <= side_s5.wr ? sat_cl : 8'd0;
			lum_s6 <= side_s5.wr ? lum_cl : 8'd0;
			side_s6 <= side_s5;
		end
	end

	// stages 7..9: back to RGB
	logic [7:0] red_o, green_o, blue_o;

	hsl_back u_back (
		.clk   (clk),
		.en    (en),
		.hue   (hue_s6),
		.sat   (sat_s6),
		.lum   (lum_s6),
		.red   (red_o),
		.green (green_o),
		.blue  (blue_o)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			side_s7 <= side_s6;
			side_s8 <= side_s7;
			side_s9 <= side_s8;
		end
	end

	assign out_data.red_out = red_o;
	assign out_data.green_out = green_o;
	assign out_data.blue_out = blue_o;
	assign out_data.alpha_out = side_s9.alpha;
	assign out_data.write_pixel = side_s9.wr;
	assign out_data.last_out = side_s9.last;

	// skipped pixels come out black
	a_skip_black: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.write_pixel |->
			out_data.red_out == 8'd0 && out_data.green_out == 8'd0 &&
			out_data.blue_out == 8'd0)
		else $error("skipped pixel with nonzero color");

	// write flag follows alpha through the pipe
	a_wr_alpha: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.write_pixel == (out_data.alpha_out != 8'd0))
		else $error("write_pixel does not match alpha");

	// input side blocked only while a result waits
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled without output stall");

	// hue shift register takes written value
	a_cfg_hue: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we && cfg_idx == CFG_HUE_SHIFT |=> hue_shift_q == $past(cfg_data[HueW-1:0]))
		else $error("hue shift write lost");

endmodule

`default_nettype wire

>>> rtl/hsl_div.sv
// hsl_div: three-stage pipelined restoring divider, 16-bit dividend by
// 8-bit divisor, 9-bit quotient (three quotient bits per stage). Uses hsl_pkg.
`default_nettype none

module hsl_div
	import hsl_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        en,
	input  wire logic [15:0] dividend,
	input  wire logic [7:0]  divisor,
	output logic [8:0]       quotient
);

	// three restoring steps starting at quotient bit top
	function automatic logic [24:0] step3(input logic [15:0] rem_i, input logic [8:0] q_i,
			input logic [7:0] d, input logic [3:0] top);
		logic [16:0] shifted;
		logic [16:0] rem;
		logic [8:0]  q;
		logic [3:0]  k;
		rem = {1'b0, rem_i};
		q = q_i;
		for (int i = 0; i < 3; i++) begin
			k = top - 4'(i);
			shifted = 17'(d) << k;
			if (rem >= shifted) begin
				rem = rem - shifted;
				q[k] = 1'b1;
			end
		end
		return {q, rem[15:0]};
	endfunction

	logic [15:0] rem_s1, rem_s2;
	logic [8:0]  q_s1, q_s2, q_s3;
	logic [7:0]  d_s1, d_s2;
	logic [24:0] r1, r2, r3;

	assign r1 = step3(dividend, 9'd0, divisor, 4'd8);
	assign r2 = step3(rem_s1, q_s1, d_s1, 4'd5);
	assign r3 = step3(rem_s2, q_s2, d_s2, 4'd2);

	// quotient bits 8..6, 5..3, 2..0
	always_ff @(posedge clk) begin
		if (en) begin
			{q_s1, rem_s1} <= r1;
			d_s1 <= divisor;
			{q_s2, rem_s2} <= r2;
			d_s2 <= d_s1;
			q_s3 <= r3[24:16];
		end
	end

	assign quotient = q_s3;

endmodule

`default_nettype wire

>>> rtl/hsl_back.sv
// hsl_back: three-stage HSL to RGB conversion (chroma, hue ramp, channel sum).
// Uses hsl_pkg; driven by the stage enable of hsl_adjust_pixel.
`default_nettype none

module hsl_back
	import hsl_pkg::*;
(
	input  wire logic            clk,
	input  wire logic            en,
	input  wire logic [HueW-1:0] hue,
	input  wire logic [7:0]      sat,
	input  wire logic [7:0]      lum,
	output logic [7:0]           red,
	output logic [7:0]           green,
	output logic [7:0]           blue
);

	logic [8:0]  l2;
	logic [7:0]  fold;
	logic [15:0] chroma_prod;

	logic [7:0]  c_s7;
	logic [8:0]  l2_s7;
	logic [HueW-1:0] hue_s7;

	logic [8:0]  m_diff;
	logic [7:0]  ramp;
	logic [15:0] x_prod;

	logic [7:0]  m_s8, c_s8;
	logic [2:0]  sext_s8;
	logic [15:0] x_prod_s8;

	logic [8:0]  rr, gg, bb, x9, c9, m9;
	logic [7:0]  red_s9, green_s9, blue_s9;

	// chroma from saturation and folded lightness
	always_comb begin
		l2 = {lum, 1'b0};
		fold = (l2 > 9'hFF) ? 8'(9'h1FF - l2) : l2[7:0];
		chroma_prod = 16'(sat) * 16'(fold);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c_s7 <= chroma_prod[15:8];
			l2_s7 <= l2;
			hue_s7 <= hue;
		end
	end

	// rising ramp in even sextants, falling ramp in odd ones
	always_comb begin
		m_diff = l2_s7 - 9'(c_s7);
		ramp = hue_s7[8] ? (8'hFF - hue_s7[7:0]) : hue_s7[7:0];
		x_prod = 16'(ramp) * 16'(c_s7);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_s8 <= m_diff[8:1];
			c_s8 <= c_s7;
			sext_s8 <= hue_s7[10:8];
			x_prod_s8 <= x_prod;
		end
	end

	// place chroma and ramp per sextant
	always_comb begin
		m9 = 9'(m_s8);
		c9 = m9 + 9'(c_s8);
		x9 = m9 + 9'(x_prod_s8[15:8]);
		rr = m9;
		gg = m9;
		bb = m9;
		unique case (sext_s8)
			3'd0: begin rr = c9; gg = x9; end
			3'd1: begin rr = x9; gg = c9; end
			3'd2: begin gg = c9; bb = x9; end
			3'd3: begin gg = x9; bb = c9; end
			3'd4: begin rr = x9; bb = c9; end
			default: begin rr = c9; bb = x9; end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			red_s9 <= rr[7:0];
			green_s9 <= gg[7:0];
			blue_s9 <= bb[7:0];
		end
	end

	assign red = red_s9;
	assign green = green_s9;
	assign blue = blue_s9;

endmodule

`default_nettype wire

>>> tb/hsl_checker.sv
// hsl_checker: watches the pixel channels of hsl_adjust_pixel, predicts each
// adjusted pixel and compares. Depends on hsl_pkg; counts failures for the top.
`default_nettype none

module hsl_checker
	import hsl_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	input  wire logic               in_ready,
	input  wire pix_in_t            in_data,
	input  wire logic               out_valid,
	input  wire logic               out_ready,
	input  wire pix_out_t           out_data,
	input  wire logic               cfg_we,
	input  wire logic [CfgIdxW-1:0] cfg_idx,
	input  wire logic [CfgW-1:0]    cfg_data,
	output int                      fail_count,
	output int                      pending
);

	logic [10:0] hue_shift_q;
	logic [11:0] sat_gain_q;
	logic [11:0] lum_gain_q;
	logic [8:0]  lum_offset_q;
	pix_out_t    expected_pixels[$];

	// doubled lightness folded around mid-gray
	function automatic int fold(input int l2);
		return (l2 > 255) ? (511 - l2) : l2;
	endfunction

	// expected adjusted pixel under the current register values
	function automatic pix_out_t adjust_pixel(input pix_in_t p);
		int r, g, b, c, l2, num, base, h, s, l, off, cc, m, h0, h1, rr, gg, bb;
		pix_out_t o;
		o = '0;
		o.last_out = p.last_in;
		if (p.alpha_in == 8'd0)
			return o;
		r = p.red_in; g = p.green_in; b = p.blue_in;
		if (r > g) begin
			if (r > b) begin
				c = (g < b) ? r - g : r - b;
				l2 = (g < b) ? r + g : r + b;
				num = g - b;
				base = (g < b) ? 1536 : 0;
			end else begin
				c = b - g; l2 = b + g; num = r - g; base = 1024;
			end
		end else if (r < b) begin
			if (g > b) begin
				c = g - r; l2 = g + r; num = b - r; base = 512;
			end else begin
				c = b - r; l2 = b + r; num = r - g; base = 1024;
			end
		end else begin
			c = g - b; l2 = g + b; num = b - r; base = 512;
		end
		h = (c == 0) ? 0 : (256 * num) / c + base;
		if (l2 == 0) begin
			s = 0; l = 0;
		end else begin
			s = (256 * c) / fold(l2);
			l = l2 / 2;
		end
		h = (h + int'(hue_shift_q)) % 1536;
		s = s * int'(sat_gain_q) / 256;
		if (s > 255) s = 255;
		off = int'($signed(lum_offset_q));
		l = l * int'(lum_gain_q) / 256 + off;
		if (l > 255) l = 255;
		if (l < 0) l = 0;
		// back to RGB
		l2 = 2 * l;
		cc = s * fold(l2) / 256;
		m = (l2 - cc) / 2;
		h0 = h & 255;
		h1 = 255 - h0;
		rr = m; gg = m; bb = m;
		case (h >> 8)
			0: begin rr = m + cc; gg = m + h0 * cc / 256; end
			1: begin rr = m + h1 * cc / 256; gg = m + cc; end
			2: begin gg = m + cc; bb = m + h0 * cc / 256; end
			3: begin gg = m + h1 * cc / 256; bb = m + cc; end
			4: begin rr = m + h0 * cc / 256; bb = m + cc; end
			default: begin rr = m + cc; bb = m + h1 * cc / 256; end
		endcase
		o.red_out = rr[7:0];
		o.green_out = gg[7:0];
		o.blue_out = bb[7:0];
		o.alpha_out = p.alpha_in;
		o.write_pixel = 1'b1;
		return o;
	endfunction

	assign pending = expected_pixels.size();

	// register shadow, prediction and comparison
	always @(posedge clk or negedge arst_n) begin
		pix_out_t want;
		if (!arst_n) begin
			hue_shift_q <= 11'd0;
			sat_gain_q <= 12'd256;
			lum_gain_q <= 12'd256;
			lum_offset_q <= 9'd0;
			fail_count <= 0;
			expected_pixels.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_idx_t'(cfg_idx))
					CFG_HUE_SHIFT:  hue_shift_q <= cfg_data[10:0];
					CFG_SAT_GAIN:   sat_gain_q <= cfg_data;
					CFG_LUM_GAIN:   lum_gain_q <= cfg_data;
					CFG_LUM_OFFSET: lum_offset_q <= cfg_data[8:0];
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				expected_pixels.push_back(adjust_pixel(in_data));
			if (out_valid && out_ready) begin
				if (expected_pixels.size() == 0) begin
					$display("%0t: unexpected pixel %h", $time, out_data);
					fail_count <= fail_count + 1;
				end else begin
					want = expected_pixels.pop_front();
					if (want !== out_data) begin
						$display("%0t: mismatch expected r%h g%h b%h a%h w%b l%b", $time,
							want.red_out, want.green_out, want.blue_out, want.alpha_out,
							want.write_pixel, want.last_out);
						$display("%0t:            actual r%h g%h b%h a%h w%b l%b", $time,
							out_data.red_out, out_data.green_out, out_data.blue_out,
							out_data.alpha_out, out_data.write_pixel, out_data.last_out);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end

endmodule

`default_nettype wire

>>> tb/testbench.sv
// testbench: drives pixels and register writes into hsl_adjust_pixel and
// gives the verdict. Depends on hsl_pkg, hsl_adjust_pixel and hsl_checker.
`default_nettype none

module testbench;
	import hsl_pkg::*;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	pix_in_t            in_data;
	logic               out_valid;
	logic               out_ready;
	pix_out_t           out_data;
	logic               cfg_we;
	logic [CfgIdxW-1:0] cfg_idx;
	logic [CfgW-1:0]    cfg_data;
	int                 fail_count;
	int                 pending;
	int                 send_idle_pct;
	int                 recv_idle_pct;
	int                 pixel_count;

	hsl_adjust_pixel u_top (.*);

	hsl_checker u_checker (.*);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// receiver stalls
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_ready <= 1'b0;
		else
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// send one pixel, idling at random first; valid stays high back to back
	task automatic send_pixel(input pix_in_t p);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= p;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		pixel_count++;
	endtask

	// drop valid and wait until every item has left the block
	task automatic drain;
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	task automatic send_rgba(input int r, input int g, input int b, input int a);
		send_pixel({8'(r), 8'(g), 8'(b), 8'(a), 1'($urandom_range(1))});
	endtask

	// random pixel: mostly nonzero alpha, some gray, some transparent
	task automatic send_random;
		pix_in_t p;
		int k;
		p = pix_in_t'({$urandom, 1'($urandom_range(1))});
		k = $urandom_range(9);
		if (k == 0) p.alpha_in = 8'd0;
		else if (k == 1) begin
			p.green_in = p.red_in;
			p.blue_in = p.red_in;
		end else if (k == 2) p.green_in = p.red_in;
		send_pixel(p);
	endtask

	// wait out all pixels in flight, then write one register
	task automatic write_reg(input cfg_idx_t idx, input int value);
		drain();
		repeat (12) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= CfgW'(value);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_regs(input int hs, input int sg, input int lg, input int lo);
		write_reg(CFG_HUE_SHIFT, hs);
		write_reg(CFG_SAT_GAIN, sg);
		write_reg(CFG_LUM_GAIN, lg);
		write_reg(CFG_LUM_OFFSET, lo);
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_we = 1'b0;
		cfg_idx = '0;
		cfg_data = '0;
		send_idle_pct = 7;
		recv_idle_pct = 70;
		pixel_count = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes, gray, black, each hue sextant, skipped pixel
		send_rgba(0, 0, 0, 255);
		send_rgba(255, 255, 255, 1);
		send_rgba(128, 128, 128, 128);
		send_rgba(255, 0, 0, 255);
		send_rgba(255, 255, 0, 255);
		send_rgba(0, 255, 0, 255);
		send_rgba(0, 255, 255, 255);
		send_rgba(0, 0, 255, 255);
		send_rgba(255, 0, 255, 255);
		send_rgba(200, 10, 100, 255);
		send_rgba(10, 200, 100, 255);
		send_rgba(255, 255, 255, 0);
		send_rgba(1, 2, 3, 254);
		// high gains push channels past 255
		set_regs(1535, 4095, 4095, 255);
		send_rgba(255, 0, 0, 255);
		send_rgba(10, 200, 100, 255);
		send_rgba(1, 2, 3, 254);
		send_rgba(128, 128, 128, 128);
		set_regs(2047, 0, 0, 9'h100);
		send_rgba(200, 10, 100, 255);
		send_rgba(0, 255, 255, 255);
		set_regs(0, 256, 256, 0);

		// random phases with different register settings and idling
		for (int phase = 0; phase < 7; phase++) begin
			if (phase == 2) begin
				send_idle_pct = 70; recv_idle_pct = 7;
			end else if (phase == 4) begin
				send_idle_pct = 0; recv_idle_pct = 0;
			end
			if (phase > 0)
				set_regs($urandom_range(2047), $urandom_range(4095),
					$urandom_range(4095), $urandom_range(511));
			repeat (100) send_random();
		end

		drain();
		repeat (20) @(posedge clk);
		$display("Sent %0d pixels over several hue, gain and offset settings,", pixel_count);
		$display("with gray, black, transparent and overflowing cases.");
		if (fail_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		#2000000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule

`default_nettype wire

>>> files.f
rtl/hsl_pkg.sv
rtl/hsl_div.sv
rtl/hsl_back.sv
rtl/hsl_adjust_pixel.sv
tb/hsl_checker.sv
tb/testbench.sv
